### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/nsp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsp_pkg
// Types, codes and helpers of the next sensor predictor.
// ---------------------------------------------------------------------------
package nsp_pkg;

	localparam int DEF_NODE_COUNT = 256;
	localparam int DEF_WALK_LIMIT = 256;
	localparam int SWITCH_SLOTS   = 22;
	localparam int SLOT_W         = 5;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SWITCH = 2'd1;
	localparam logic [1:0] OP_SENSOR = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [2:0] TYPE_SENSOR = 3'd1;
	localparam logic [2:0] TYPE_BRANCH = 3'd2;
	localparam logic [2:0] TYPE_EXIT   = 3'd5;

	localparam logic [7:0] NO_NODE = 8'hFF;

	localparam logic KIND_SWITCH = 1'b0;
	localparam logic KIND_SENSOR = 1'b1;

	typedef struct packed {
		logic [2:0]  ntype;
		logic [7:0]  num;
		logic [7:0]  sdest;
		logic [15:0] sdist;
		logic [7:0]  cdest;
		logic [15:0] cdist;
	} node_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  switch_id;
		logic        switch_straight;
		logic [31:0] event_ticks;
		logic        last_matched;
		logic [31:0] time_error_ticks;
		logic [31:0] dist_error_mm;
		logic        has_prediction;
		logic [3:0]  predicted_bank;
		logic [4:0]  predicted_number;
		logic [31:0] predicted_ticks;
	} result_t;

	// ids 1-18 -> 0-17, 153-156 -> 18-21, others -> SWITCH_SLOTS
	function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] id);
		logic [SLOT_W-1:0] s;
		s = SLOT_W'(SWITCH_SLOTS);
		if (id >= 8'd1 && id <= 8'd18) s = SLOT_W'(id - 8'd1);
		else if (id >= 8'd153 && id <= 8'd156) s = SLOT_W'(id - 8'd135);
		return s;
	endfunction

endpackage

### sv/nsp_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsp_req_if
// Request channel: operation and its operand fields.
// ---------------------------------------------------------------------------
interface nsp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  node_index;
	logic [2:0]  node_type;
	logic [7:0]  item_number;
	logic [7:0]  straight_dest;
	logic [15:0] straight_dist;
	logic [7:0]  curved_dest;
	logic [15:0] curved_dist;
	logic [2:0]  sensor_bank;
	logic [4:0]  sensor_number;
	logic        flag;
	logic [31:0] tick_value;

	modport source (output valid, operation, node_index, node_type, item_number,
		straight_dest, straight_dist, curved_dest, curved_dist, sensor_bank,
		sensor_number, flag, tick_value, input ready);
	modport sink (input valid, operation, node_index, node_type, item_number,
		straight_dest, straight_dist, curved_dest, curved_dist, sensor_bank,
		sensor_number, flag, tick_value, output ready);
endinterface

### sv/nsp_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsp_rsp_if
// Result channel: switch commands and sensor reports.
// ---------------------------------------------------------------------------
interface nsp_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  switch_id;
	logic        switch_straight;
	logic [31:0] event_ticks;
	logic        last_matched;
	logic signed [31:0] time_error_ticks;
	logic signed [31:0] dist_error_mm;
	logic        has_prediction;
	logic [3:0]  predicted_bank;
	logic [4:0]  predicted_number;
	logic [31:0] predicted_ticks;

	modport source (output valid, kind, switch_id, switch_straight, event_ticks,
		last_matched, time_error_ticks, dist_error_mm, has_prediction,
		predicted_bank, predicted_number, predicted_ticks, input ready);
	modport sink (input valid, kind, switch_id, switch_straight, event_ticks,
		last_matched, time_error_ticks, dist_error_mm, has_prediction,
		predicted_bank, predicted_number, predicted_ticks, output ready);
endinterface

### sv/next_sensor_predictor_core.sv
`timescale 1ns / 1ps
// Load, tick: no result. Switch set: result in the next cycle, none for an unknown switch id.
// Sensor event (flag set): a walk of N node reads, one per cycle from the node RAM, then the divide
// by three; a walk that ends without a prediction gives its result without the divide.
// One request in flight at a time; the next is taken once the result register is free.
// Reset (arst_n low): switches straight, tick and last prediction zero; node RAM not cleared.
// ---------------------------------------------------------------------------
// next_sensor_predictor_core
// Track graph walker predicting the next sensor and its arrival tick.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module next_sensor_predictor_core import nsp_pkg::*; #(
	parameter int NODE_COUNT = DEF_NODE_COUNT,
	parameter int WALK_LIMIT = DEF_WALK_LIMIT
) (
	input logic clk,
	input logic arst_n,
	nsp_req_if.sink   req,
	nsp_rsp_if.source rsp
);
	localparam int AW = $clog2(NODE_COUNT);
	localparam int SW = $clog2(WALK_LIMIT + 1);
	localparam logic [8:0]    NC = 9'(NODE_COUNT);
	localparam logic [SW-1:0] WL = SW'(WALK_LIMIT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_NODE  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;

	logic [2:0]  state_q;
	logic [SWITCH_SLOTS-1:0] sw_pos_q;
	logic [31:0] tick_q;
	logic        last_has_q;
	logic [7:0]  last_sensor_q;
	logic [31:0] last_tick_q;
	logic [31:0] dist_q;
	logic [SW-1:0] steps_q;
	logic [7:0]  found_q;
	result_t     res_q;
	logic        res_valid_q;

	logic        accept;
	logic        ram_we;
	logic [AW-1:0] ram_addr;
	node_t       wnode;
	node_t       rnode;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;

	logic [SLOT_W-1:0] set_slot;
	logic [SLOT_W-1:0] br_slot;
	logic        straight;
	logic [7:0]  next_dest;
	logic [15:0] edge_len;
	logic [32:0] dist_sum;
	logic [31:0] dist_next;
	logic        dest_ok;
	logic [7:0]  sens_idx;
	logic        matched;
	logic [31:0] terr;
	logic [7:0]  start_dest;
	logic        start_ok;
	result_t     res_init;
	result_t     res_fin;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && (!res_valid_q || rsp.ready);

	assign wnode = '{ntype: req.node_type, num: req.item_number, sdest: req.straight_dest,
		sdist: req.straight_dist, cdest: req.curved_dest, cdist: req.curved_dist};

	assign set_slot = slot_of(req.item_number);
	assign sens_idx = 8'({1'b0, req.sensor_bank, 4'b0} + {3'b0, req.sensor_number} + 8'hFF);
	assign matched  = last_has_q && (last_sensor_q[7:4] == {1'b0, req.sensor_bank}) &&
		({1'b0, last_sensor_q[3:0]} + 5'd1 == req.sensor_number);
	assign terr     = tick_q - last_tick_q;

	// edge selection for the node just read
	assign br_slot   = slot_of(rnode.num);
	assign straight  = (rnode.ntype != TYPE_BRANCH) ||
		((br_slot < SLOT_W'(SWITCH_SLOTS)) && sw_pos_q[br_slot]);
	assign next_dest = straight ? rnode.sdest : rnode.cdest;
	assign edge_len  = straight ? rnode.sdist : rnode.cdist;
	assign dist_sum  = {1'b0, dist_q} + {17'b0, edge_len};
	assign dist_next = dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];
	assign dest_ok   = (next_dest != NO_NODE) && ({1'b0, next_dest} < NC);
	assign start_dest = rnode.sdest;
	assign start_ok  = (start_dest != NO_NODE) && ({1'b0, start_dest} < NC);

	// result payload at accept, and with the prediction filled in
	always_comb begin
		res_init = '0;
		if (req.operation == OP_SWITCH) begin
			res_init.kind            = KIND_SWITCH;
			res_init.switch_id       = req.item_number;
			res_init.switch_straight = req.flag;
		end else begin
			res_init.kind        = KIND_SENSOR;
			res_init.event_ticks = tick_q;
			if (matched) begin
				res_init.last_matched     = 1'b1;
				res_init.time_error_ticks = terr;
				res_init.dist_error_mm    = {terr[30:0], 1'b0} + terr;
			end
		end
		res_fin = res_q;
		res_fin.has_prediction   = 1'b1;
		res_fin.predicted_bank   = found_q[7:4];
		res_fin.predicted_number = {1'b0, found_q[3:0]} + 5'd1;
		res_fin.predicted_ticks  = tick_q + div_quo;
	end

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = req.node_index[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && req.operation == OP_LOAD && {1'b0, req.node_index} < NC)
					ram_we = 1'b1;
				if (req.operation == OP_SENSOR) ram_addr = sens_idx[AW-1:0];
			end
			ST_START: ram_addr = start_dest[AW-1:0];
			ST_NODE:  ram_addr = next_dest[AW-1:0];
			default:  ram_addr = req.node_index[AW-1:0];
		endcase
	end

	nsp_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_COUNT)) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wnode),
		.rdata (rnode)
	);

	assign div_start = (state_q == ST_NODE) && (rnode.ntype == TYPE_SENSOR);

	nsp_div3 u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dist_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sw_pos_q    <= '1;
			tick_q      <= '0;
			last_has_q  <= 1'b0;
			last_sensor_q <= '0;
			last_tick_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && rsp.ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.operation)
							OP_TICK: tick_q <= req.tick_value;
							OP_SWITCH: begin
								if (set_slot < SLOT_W'(SWITCH_SLOTS)) begin
									sw_pos_q[set_slot] <= req.flag;
									res_valid_q <= 1'b1;
								end
							end
							OP_SENSOR: begin
								if (req.flag) begin
									if ({1'b0, sens_idx} < NC) begin
										state_q <= ST_START;
									end else begin
										res_valid_q   <= 1'b1;
										last_has_q    <= 1'b0;
										last_sensor_q <= '0;
										last_tick_q   <= '0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_START: begin
					if (start_ok) begin
						state_q <= ST_NODE;
					end else begin
						state_q       <= ST_IDLE;
						res_valid_q   <= 1'b1;
						last_has_q    <= 1'b0;
						last_sensor_q <= '0;
						last_tick_q   <= '0;
					end
				end
				ST_NODE: begin
					if (rnode.ntype == TYPE_SENSOR) begin
						state_q <= ST_DIV;
					end else if (rnode.ntype == TYPE_EXIT || steps_q >= WL || !dest_ok) begin
						state_q       <= ST_IDLE;
						res_valid_q   <= 1'b1;
						last_has_q    <= 1'b0;
						last_sensor_q <= '0;
						last_tick_q   <= '0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q       <= ST_IDLE;
						res_valid_q   <= 1'b1;
						last_has_q    <= 1'b1;
						last_sensor_q <= found_q;
						last_tick_q   <= tick_q + div_quo;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.operation == OP_SWITCH || req.operation == OP_SENSOR))
					res_q <= res_init;
			end
			ST_START: begin
				dist_q  <= {16'b0, rnode.sdist};
				steps_q <= '0;
			end
			ST_NODE: begin
				if (rnode.ntype == TYPE_SENSOR) begin
					found_q <= rnode.num;
				end else begin
					dist_q  <= dist_next;
					steps_q <= steps_q + SW'(1);
				end
			end
			ST_DIV: begin
				if (div_done) res_q <= res_fin;
			end
			default: ;
		endcase
	end

	assign rsp.valid            = res_valid_q;
	assign rsp.kind             = res_q.kind;
	assign rsp.switch_id        = res_q.switch_id;
	assign rsp.switch_straight  = res_q.switch_straight;
	assign rsp.event_ticks      = res_q.event_ticks;
	assign rsp.last_matched     = res_q.last_matched;
	assign rsp.time_error_ticks = res_q.time_error_ticks;
	assign rsp.dist_error_mm    = res_q.dist_error_mm;
	assign rsp.has_prediction   = res_q.has_prediction;
	assign rsp.predicted_bank   = res_q.predicted_bank;
	assign rsp.predicted_number = res_q.predicted_number;
	assign rsp.predicted_ticks  = res_q.predicted_ticks;

	`ASSERT_IMPLIES(a_walk_bound, state_q == ST_NODE, steps_q <= WL)
	`ASSERT_IMPLIES(a_div_owner, div_done, state_q == ST_DIV)
	`ASSERT_NEXT(a_walk_no_result, state_q == ST_NODE && rnode.ntype == TYPE_SENSOR,
		state_q == ST_DIV && !res_valid_q)
endmodule

### sv/nsp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsp_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module nsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

### sv/nsp_div3.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsp_div3
// Divide by three through a reciprocal multiply; quotient and done registered in the cycle after start.
// ---------------------------------------------------------------------------
module nsp_div3 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	output logic        done,
	output logic [31:0] quotient
);
	// ceil(2^33 / 3): floor(x * RECIP3 / 2^33) == floor(x / 3) for any 32-bit x
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	logic [63:0] prod_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) prod_q <= {32'b0, dividend} * {32'b0, RECIP3};
	end

	assign done     = done_q;
	assign quotient = {1'b0, prod_q[63:33]};
endmodule
